[hdl/ewre_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder window speed estimator package
// Shared widths, reset values and scale constants of the estimator.
// ----------------------------------------------------------------------------
package ewre_pkg;

  // Default number of samples in the moving window.
  localparam int WINDOW_DEF = 8;

  // Field widths.
  localparam int CNT_W = 16;
  localparam int MS_W  = 16;
  localparam int CPR_W = 16;
  localparam int RPM_W = 32;

  // Reset value of the counts-per-revolution register.
  localparam logic [CPR_W-1:0] CPR_RESET = 16'd2048;

  // Scale factor: 60000 ms per minute times 256 for the Q.8 fraction.
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] SCALE = 24'd15360000;

  // Saturation limits of the 32-bit result.
  localparam logic [RPM_W-1:0] RPM_MAX = 32'h7FFF_FFFF;
  localparam logic [RPM_W-1:0] RPM_MIN = 32'h8000_0000;

endpackage

[hdl/ewre_sample_if.sv]
// ----------------------------------------------------------------------------
// Speed sample channel
// Valid/ready channel that carries one encoder speed sample per word.
// ----------------------------------------------------------------------------
interface ewre_sample_if;
  import ewre_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [CNT_W-1:0] sample_count;
  logic        [MS_W-1:0]  elapsed_ms;

  modport source (output valid, output sample_count, output elapsed_ms, input ready);
  modport sink   (input valid, input sample_count, input elapsed_ms, output ready);

endinterface

[hdl/ewre_result_if.sv]
// ----------------------------------------------------------------------------
// Speed result channel
// Valid/ready channel that carries one window speed result per word.
// ----------------------------------------------------------------------------
interface ewre_result_if;
  import ewre_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RPM_W-1:0] rpm_q8;
  logic                    no_time;
  logic                    saturated;

  modport source (output valid, output rpm_q8, output no_time, output saturated,
                  input ready);
  modport sink   (input valid, input rpm_q8, input no_time, input saturated,
                  output ready);

endinterface

[hdl/ewre_ring.sv]
// ----------------------------------------------------------------------------
// Sample ring with running sums
// Holds the last Window samples in a small memory with per-entry valid bits
// and keeps the running sums of counts and of milliseconds.
// ----------------------------------------------------------------------------
module ewre_ring #(
  parameter int Window = ewre_pkg::WINDOW_DEF,
  parameter int CsumW  = 17 + $clog2(Window),
  parameter int TsumW  = 16 + $clog2(Window)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic                           upd_en_i,
  input  logic signed [ewre_pkg::CNT_W-1:0] sample_count_i,
  input  logic        [ewre_pkg::MS_W-1:0]  elapsed_ms_i,
  output logic signed [CsumW-1:0]        count_total_o,
  output logic        [TsumW-1:0]        interval_total_o
);
  import ewre_pkg::*;

  localparam int HeadW = (Window > 1) ? $clog2(Window) : 1;

  logic signed [CNT_W-1:0] cnt_mem [Window];
  logic        [MS_W-1:0]  ms_mem  [Window];

  logic [Window-1:0]       valid_q;
  logic [HeadW-1:0]        head_q;
  logic signed [CNT_W-1:0] old_cnt_q;
  logic        [MS_W-1:0]  old_ms_q;
  logic                    old_valid_q;
  logic signed [CsumW-1:0] csum_q;
  logic        [TsumW-1:0] tsum_q;

  logic signed [CNT_W-1:0] old_cnt;
  logic        [MS_W-1:0]  old_ms;
  logic [HeadW-1:0]        head_next;

  // Entries never written since reset read as zero.
  assign old_cnt   = old_valid_q ? old_cnt_q : '0;
  assign old_ms    = old_valid_q ? old_ms_q : '0;
  assign head_next = (head_q == HeadW'(Window - 1)) ? '0 : head_q + 1'b1;

  // Memory read and write ports.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      old_cnt_q <= cnt_mem[head_q];
      old_ms_q  <= ms_mem[head_q];
    end
    if (upd_en_i) begin
      cnt_mem[head_q] <= sample_count_i;
      ms_mem[head_q]  <= elapsed_ms_i;
    end
  end

  // Valid bits, write head and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      head_q      <= '0;
      old_valid_q <= 1'b0;
      csum_q      <= '0;
      tsum_q      <= '0;
    end else begin
      if (rd_en_i) begin
        old_valid_q <= valid_q[head_q];
      end
      if (upd_en_i) begin
        valid_q[head_q] <= 1'b1;
        head_q          <= head_next;
        csum_q          <= csum_q + CsumW'(sample_count_i) - CsumW'(old_cnt);
        tsum_q          <= tsum_q + TsumW'(elapsed_ms_i) - TsumW'(old_ms);
      end
    end
  end

  assign count_total_o    = csum_q;
  assign interval_total_o = tsum_q;

endmodule

[hdl/ewre_div.sv]
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ewre_div #(
  parameter int NumW = 43,
  parameter int DenW = 35
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] nq_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            fits;

  // One compare-and-subtract step.
  assign trial = {rem_q, nq_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = ~diff[DenW];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[NumW-2:0], fits};
      rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
    end
  end

  // Step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

[hdl/encoder_window_rpm_estimator_top.sv]
// ----------------------------------------------------------------------------
// Encoder window speed estimator
// Moving-window RPM estimate in signed Q.8 from encoder count samples.
//
// Channel    Dir   Payload
// sample_i   in    sample_count (s16), elapsed_ms (u16)
// result_o   out   rpm_q8 (s32), no_time, saturated
// cfg        in    cfg_we_i / cfg_wdata_i: counts per revolution (u16)
//
// The iterative divider produces one quotient bit per cycle; a zero time
// sum skips the divider. Reset clears the ring valid bits, sums and head
// at once; the counts-per-revolution register returns to 2048.
// The result word sits in an output register; the next sample is accepted
// while it waits, and a finished result holds until that register is free.
// ----------------------------------------------------------------------------
module encoder_window_rpm_estimator_top #(
  parameter int Window = ewre_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ewre_pkg::CPR_W-1:0]    cfg_wdata_i,
  ewre_sample_if.sink                   sample_i,
  ewre_result_if.source                 result_o
);
  import ewre_pkg::*;

  localparam int CsumW = 17 + $clog2(Window);
  localparam int TsumW = 16 + $clog2(Window);
  localparam int MagW  = CsumW - 1;
  localparam int NumW  = MagW + SCALE_W;
  localparam int DenW  = TsumW + CPR_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_MULN = 3'd2;
  localparam logic [2:0] S_MULD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [CPR_W-1:0]        cpr_q;
  logic signed [CNT_W-1:0] cnt_q;
  logic [MS_W-1:0]         ms_q;
  logic [NumW-1:0]         num_q;
  logic                    zero_q;

  logic                    out_valid_q;
  logic [RPM_W-1:0]        rpm_q;
  logic                    no_time_q;
  logic                    sat_q;

  logic                    in_acc;
  logic signed [CsumW-1:0] csum;
  logic [TsumW-1:0]        tsum;
  logic [CsumW-1:0]        csum_abs;
  logic [MagW-1:0]         mag;
  logic                    neg;
  logic [CPR_W-1:0]        cpr_eff;
  logic [MagW-1:0]         mul_a;
  logic [SCALE_W-1:0]      mul_b;
  logic [NumW-1:0]         prod;
  logic                    div_start;
  logic                    div_done;
  logic [NumW-1:0]         quo;
  logic                    hi_nz;
  logic                    sat;
  logic [RPM_W-1:0]        rpm;
  logic                    out_free;

  assign in_acc = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == S_IDLE);

  // Counts per revolution register; zero reads as one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CPR_RESET;
    end else if (cfg_we_i) begin
      cpr_q <= cfg_wdata_i;
    end
  end
  assign cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;

  // Sample capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cnt_q <= sample_i.sample_count;
      ms_q  <= sample_i.elapsed_ms;
    end
  end

  ewre_ring #(
    .Window (Window),
    .CsumW  (CsumW),
    .TsumW  (TsumW)
  ) u_ring (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rd_en_i          (in_acc),
    .upd_en_i         (state_q == S_UPD),
    .sample_count_i   (cnt_q),
    .elapsed_ms_i     (ms_q),
    .count_total_o    (csum),
    .interval_total_o (tsum)
  );

  // Sign and magnitude of the count sum.
  assign neg      = csum[CsumW-1];
  assign csum_abs = neg ? (~csum + 1'b1) : csum;
  assign mag      = csum_abs[MagW-1:0];

  // Shared multiplier: numerator first, then denominator.
  assign mul_a = (state_q == S_MULN) ? mag : MagW'(tsum);
  assign mul_b = (state_q == S_MULN) ? SCALE : SCALE_W'(cpr_eff);
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MULN) begin
      num_q <= prod;
    end
  end

  assign div_start = (state_q == S_MULD);

  ewre_div #(
    .NumW (NumW),
    .DenW (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (prod[DenW-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Sign restore and saturation to 32 bits.
  assign hi_nz = |quo[NumW-1:RPM_W-1];
  assign sat   = neg ? (hi_nz && (quo != NumW'(RPM_MIN))) : hi_nz;
  always_comb begin
    if (neg) begin
      rpm = sat ? RPM_MIN : (~quo[RPM_W-1:0] + 1'b1);
    end else begin
      rpm = sat ? RPM_MAX : quo[RPM_W-1:0];
    end
  end

  assign out_free = !out_valid_q || result_o.ready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_UPD;
      S_UPD:  state_d = S_MULN;
      S_MULN: state_d = (tsum == '0) ? S_DONE : S_MULD;
      S_MULD: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MULN) begin
        zero_q <= (tsum == '0);
      end
    end
  end

  // Result register holding the sign-restored, saturated quotient once the divider finishes.
  logic [RPM_W-1:0] res_rpm_q;
  logic             res_sat_q;

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      res_rpm_q <= rpm;
      res_sat_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      rpm_q     <= zero_q ? '0 : res_rpm_q;
      no_time_q <= zero_q;
      sat_q     <= zero_q ? 1'b0 : res_sat_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.rpm_q8    = rpm_q;
  assign result_o.no_time   = no_time_q;
  assign result_o.saturated = sat_q;

endmodule

[tb/sv/encoder_window_rpm_estimator_top_test.sv]
// ----------------------------------------------------------------------------
// Encoder window speed estimator testbench
// Drives speed samples through the valid/ready sample channel and checks
// every result word against a cycle-free predictor of the moving window.
// The counts-per-revolution register is rewritten between phases while
// the block is idle. Both channels idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_window_rpm_estimator_top_test;
  import ewre_pkg::*;

  // One speed sample as it is queued for the driver.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [MS_W-1:0]  ms;
  } sample_word_t;

  // One expected result word.
  typedef struct packed {
    logic [RPM_W-1:0] rpm_q8;
    logic             no_time;
    logic             saturated;
  } speed_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CPR_W-1:0] cfg_wdata_i;

  ewre_sample_if sample_bus ();
  ewre_result_if result_bus ();

  encoder_window_rpm_estimator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_bus),
    .result_o    (result_bus)
  );

  // Sample words waiting for the driver and speeds waiting for the block.
  sample_word_t pending_samples[$];
  speed_word_t  expected_speeds[$];

  // Predictor copy of the window and the register.
  logic signed [CNT_W-1:0] count_hist[WINDOW_DEF];
  logic [MS_W-1:0]         ms_hist[WINDOW_DEF];
  int unsigned             hist_head;
  longint                  count_sum;
  longint                  ms_sum;
  logic [CPR_W-1:0]        rev_counts;

  int          words_issued;
  int          words_received;
  int          error_count;
  logic        sample_taken;
  logic        calm;
  int          send_gap;
  int          stall_left;
  int          hold_left;
  logic        long_hold_done;
  sample_word_t next_word;
  speed_word_t  oldest_speed;

  // Clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Window speed for one new sample; advances the predictor state.
  function automatic speed_word_t predict_window_speed(input logic [CNT_W-1:0] cnt,
                                                       input logic [MS_W-1:0] ms);
    int unsigned slot;
    longint      divisor;
    longint      num;
    longint      den;
    longint      quot;
    speed_word_t res;
    slot = hist_head;
    count_sum += longint'($signed(cnt)) - longint'(count_hist[slot]);
    ms_sum += longint'(ms) - longint'(ms_hist[slot]);
    count_hist[slot] = cnt;
    ms_hist[slot] = ms;
    hist_head = (slot + 1 >= WINDOW_DEF) ? 0 : slot + 1;
    res = '0;
    if (ms_sum == 0) begin
      res.no_time = 1'b1;
    end else begin
      // A register value of zero counts as one count per revolution.
      divisor = (rev_counts == '0) ? 64'sd1 : longint'(rev_counts);
      num = count_sum * longint'(SCALE);
      den = ms_sum * divisor;
      quot = num / den;
      if (quot > 64'sd2147483647) begin
        quot = 64'sd2147483647;
        res.saturated = 1'b1;
      end else if (quot < -64'sd2147483648) begin
        quot = -64'sd2147483648;
        res.saturated = 1'b1;
      end
      res.rpm_q8 = quot[RPM_W-1:0];
    end
    return res;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 1;
    end else if (r < 90) begin
      return $urandom_range(2, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // Random sample biased toward small counts and short intervals.
  function automatic sample_word_t random_sample();
    sample_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      w.cnt = 16'($urandom_range(0, 400) - 200);
    end else if (r < 80) begin
      w.cnt = 16'($urandom);
    end else if (r < 90) begin
      w.cnt = 16'h7FFF;
    end else begin
      w.cnt = 16'h8000;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      w.ms = '0;
    end else if (r < 70) begin
      w.ms = 16'($urandom_range(1, 20));
    end else if (r < 90) begin
      w.ms = 16'($urandom);
    end else begin
      w.ms = 16'hFFFF;
    end
    return w;
  endfunction

  task automatic queue_sample(input logic [CNT_W-1:0] cnt, input logic [MS_W-1:0] ms);
    sample_word_t w;
    w.cnt = cnt;
    w.ms = ms;
    pending_samples.push_back(w);
    words_issued++;
  endtask

  // Random phase; now and then a full window of zero intervals.
  task automatic queue_random_phase(input int n);
    int pushed;
    int run;
    sample_word_t w;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 99) < 3) begin
        run = $urandom_range(WINDOW_DEF, WINDOW_DEF + 2);
        repeat (run) begin
          w = random_sample();
          queue_sample(w.cnt, '0);
        end
        pushed += run;
      end else begin
        w = random_sample();
        queue_sample(w.cnt, w.ms);
        pushed++;
      end
    end
  endtask

  // Wait until every queued sample has come back as a result word.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (words_received != words_issued);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_rev_counts(input logic [CPR_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sample driver: holds a word until accepted, then idles or sends the next.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sample_bus.valid && !sample_taken) begin
        // Word still waiting for ready.
      end else if (send_gap > 0) begin
        send_gap--;
        sample_bus.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        next_word = pending_samples.pop_front();
        sample_bus.valid <= 1'b1;
        sample_bus.sample_count <= next_word.cnt;
        sample_bus.elapsed_ms <= next_word.ms;
        send_gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
      end else begin
        sample_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off to back up the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (!long_hold_done && words_received >= 100) begin
        long_hold_done = 1'b1;
        hold_left = 400;
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) begin
          stall_left = gap_len();
        end
      end
    end
  end

  // Check result words, track register writes and predict accepted samples.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_bus.valid && sample_bus.ready;
      if (result_bus.valid && result_bus.ready) begin
        words_received++;
        if (expected_speeds.size() == 0) begin
          $error("result word with no sample pending: rpm_q8 %0d",
                 $signed(result_bus.rpm_q8));
          error_count++;
        end else begin
          oldest_speed = expected_speeds.pop_front();
          if (result_bus.rpm_q8 !== oldest_speed.rpm_q8) begin
            $error("rpm_q8 mismatch: expected %0d, actual %0d",
                   $signed(oldest_speed.rpm_q8), $signed(result_bus.rpm_q8));
            error_count++;
          end
          if (result_bus.no_time !== oldest_speed.no_time) begin
            $error("no_time mismatch: expected %0b, actual %0b",
                   oldest_speed.no_time, result_bus.no_time);
            error_count++;
          end
          if (result_bus.saturated !== oldest_speed.saturated) begin
            $error("saturated mismatch: expected %0b, actual %0b",
                   oldest_speed.saturated, result_bus.saturated);
            error_count++;
          end
        end
      end
      if (cfg_we_i) begin
        rev_counts = cfg_wdata_i;
      end
      if (sample_bus.valid && sample_bus.ready) begin
        expected_speeds.push_back(
          predict_window_speed(sample_bus.sample_count, sample_bus.elapsed_ms));
      end
    end
  end

  // Stimulus: directed corners, then random phases over several settings.
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    sample_bus.valid = 1'b0;
    sample_bus.sample_count = '0;
    sample_bus.elapsed_ms = '0;
    result_bus.ready = 1'b0;
    for (int i = 0; i < WINDOW_DEF; i++) begin
      count_hist[i] = '0;
      ms_hist[i] = '0;
    end
    hist_head = 0;
    count_sum = 0;
    ms_sum = 0;
    rev_counts = CPR_RESET;
    words_issued = 0;
    words_received = 0;
    error_count = 0;
    calm = 1'b0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register value: empty window, extremes, then a window of zero time.
    queue_sample(16'h0000, 16'd0);
    queue_sample(16'h7FFF, 16'd1);
    queue_sample(16'h8000, 16'hFFFF);
    queue_sample(16'h7FFF, 16'hFFFF);
    queue_sample(16'hFFFF, 16'd0);
    repeat (WINDOW_DEF) queue_sample(16'h8000, 16'd0);

    // One count per revolution: clip low, then clip high.
    write_rev_counts(16'd1);
    queue_sample(16'h7FFF, 16'd1);
    repeat (WINDOW_DEF - 1) queue_sample(16'h7FFF, 16'd0);
    queue_sample(16'h0000, 16'hFFFF);

    // Largest register value.
    write_rev_counts(16'hFFFF);
    queue_sample(16'h7FFF, 16'hFFFF);
    queue_sample(16'h8000, 16'd1);

    // Zero register value reads as one.
    write_rev_counts(16'd0);
    queue_sample(16'd100, 16'd3);
    queue_sample(16'hFFF9, 16'd0);

    // Random phases; the sender pauses for a full drain before each write.
    write_rev_counts(CPR_RESET);
    queue_random_phase(141);
    write_rev_counts(16'($urandom_range(1, 65535)));
    queue_random_phase(141);
    write_rev_counts(16'd1);
    queue_random_phase(141);
    write_rev_counts(16'hFFFF);
    calm = 1'b1;
    queue_random_phase(141);
    write_rev_counts(16'd0);
    calm = 1'b0;
    queue_random_phase(141);
    write_rev_counts(16'($urandom_range(1, 16)));
    queue_random_phase(141);
    write_rev_counts(16'($urandom_range(100, 5000)));
    calm = 1'b1;
    queue_random_phase(141);
    write_rev_counts(16'h8000);
    calm = 1'b0;
    queue_random_phase(141);

    // Drain, then leave room for any stray result word.
    wait_idle();
    repeat (60) @(negedge clk_i);
    if (expected_speeds.size() != 0) begin
      $error("%0d expected result words never arrived", expected_speeds.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
hdl/ewre_pkg.sv
hdl/ewre_sample_if.sv
hdl/ewre_result_if.sv
hdl/ewre_ring.sv
hdl/ewre_div.sv
hdl/encoder_window_rpm_estimator_top.sv
tb/sv/encoder_window_rpm_estimator_top_test.sv
